/* hw/rtl/wr2s_pkg.sv */
// ============================================================================
// wr2s_pkg
// Shared types and constants for the weighted wR2 block with scale.
// ============================================================================
package wr2s_pkg;

    localparam int MAX_ITEMS = 4096;
    localparam int COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] ITEM_LIMIT = COUNT_W'(MAX_ITEMS);
    localparam logic [COUNT_W-1:0] ITEM_OVER  = COUNT_W'(MAX_ITEMS + 1);

    // configuration port
    localparam int IDX_W  = 2;
    localparam int DATA_W = 32;
    localparam logic [IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESET_SCALE = 2'd1;
    localparam logic [31:0]      PRESET_RESET     = 32'h0001_0000;

    // datapath widths
    localparam int ACC_W  = 160;
    localparam int DEN_W  = 120;
    localparam int QUO_W  = 64;
    localparam int ROOT_W = 32;
    localparam int SREM_W = 33;
    localparam int CAND_W = 42;
    localparam int MULT_W = 21;
    localparam int PROD_W = 52;

    // sequencer counter ends
    localparam int SEQ_W = 7;
    localparam logic [SEQ_W-1:0] PROD_END = 7'd20;
    localparam logic [SEQ_W-1:0] WACC_END = 7'd9;
    localparam logic [SEQ_W-1:0] MUL_END  = 7'd63;
    localparam logic [SEQ_W-1:0] DIV_END  = 7'd63;
    localparam logic [SEQ_W-1:0] SQRT_END = 7'd31;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OBS_ZERO  = 2'd1,
        ERR_CALC_ZERO = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_PROD   = 11'b000_0000_0010,
        S_WACC   = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_MUL    = 11'b000_0001_0000,
        S_STEP   = 11'b000_0010_0000,
        S_DIVLD  = 11'b000_0100_0000,
        S_DIV    = 11'b000_1000_0000,
        S_AFTDIV = 11'b001_0000_0000,
        S_SQRT   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        STEP_DEN = 3'd0,
        STEP_NUM = 3'd1,
        STEP_SCL = 3'd2,
        STEP_TT  = 3'd3,
        STEP_TSC = 3'd4,
        STEP_TDC = 3'd5
    } step_t;

    typedef struct packed {
        logic signed [19:0] obs_value;
        logic signed [19:0] calc_value;
        logic        [9:0]  weight;
        logic               last;
    } in_t;

    typedef struct packed {
        logic        [31:0] wr2_value;
        logic signed [31:0] scale_used;
        logic        [1:0]  error_code;
    } out_t;

endpackage

/* hw/rtl/weighted_r2_with_scale.sv */
// ============================================================================
// weighted_r2_with_scale
// Weighted agreement factor wR2 with least-squares or preset scale.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  in        | in_valid / in_ready   | in_data  (obs, calc, weight, last)
//  out       | out_valid / out_ready | out_data (wr2, scale, error code)
//  config    | wr_en                 | wr_index, wr_data
//
//  an item goes through bit-serial squaring of the inputs,
//  then bit-serial weighting into the sums, one bit per cycle
//  a closing item adds a shift-add multiplier, a restoring divider
//  and a square root
//  reset is asynchronous, clears the sums and loads the register defaults
//  the output register holds a result while the next set is accumulated;
//  a new result waits in its last state until that register is free
//
module weighted_r2_with_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [wr2s_pkg::IDX_W-1:0]          wr_index,
    input  logic [wr2s_pkg::DATA_W-1:0]         wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wr2s_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output wr2s_pkg::out_t                      out_data
);

    // control state
    wr2s_pkg::state_t state_reg, state_next;
    wr2s_pkg::step_t  step_reg, step_next;
    logic [wr2s_pkg::SEQ_W-1:0]   cnt_reg, cnt_next;
    logic [wr2s_pkg::COUNT_W-1:0] item_count_reg, item_count_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         scale_mode_reg;
    logic [31:0]                  preset_scale_reg;

    // running sums
    logic [59:0]        soo_reg, soo_next;
    logic [59:0]        scc_reg, scc_next;
    logic signed [60:0] sco_reg, sco_next;
    logic [61:0]        sdd_reg, sdd_next;

    // per-transaction serial products
    logic                           last_reg, last_next;
    logic                           co_neg_reg, co_neg_next;
    logic [9:0]                     w_reg, w_next;
    logic [wr2s_pkg::CAND_W-1:0]    cand_o_reg, cand_o_next;
    logic [wr2s_pkg::CAND_W-1:0]    cand_c_reg, cand_c_next;
    logic [wr2s_pkg::CAND_W-1:0]    cand_d_reg, cand_d_next;
    logic [wr2s_pkg::MULT_W-1:0]    mult_o_reg, mult_o_next;
    logic [wr2s_pkg::MULT_W-1:0]    mult_c_reg, mult_c_next;
    logic [wr2s_pkg::MULT_W-1:0]    mult_d_reg, mult_d_next;
    logic [wr2s_pkg::PROD_W-1:0]    poo_reg, poo_next;
    logic [wr2s_pkg::PROD_W-1:0]    pcc_reg, pcc_next;
    logic [wr2s_pkg::PROD_W-1:0]    pco_reg, pco_next;
    logic [wr2s_pkg::PROD_W-1:0]    pdd_reg, pdd_next;

    // closing datapath
    logic [wr2s_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [wr2s_pkg::ACC_W-1:0]     mula_reg, mula_next;
    logic [63:0]                    mulb_reg, mulb_next;
    logic                           sub_reg, sub_next;
    logic [wr2s_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [wr2s_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [wr2s_pkg::QUO_W-1:0]     quot_reg, quot_next;
    logic [wr2s_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [wr2s_pkg::SREM_W-1:0]    srem_reg, srem_next;
    logic [31:0]                    wr2_reg, wr2_next;
    logic [31:0]                    scl_reg, scl_next;
    wr2s_pkg::err_t                 err_reg, err_next;
    wr2s_pkg::out_t                 out_data_reg, out_data_next;

    // input magnitudes
    logic signed [20:0] o_ext, c_ext, d_ext;
    logic [20:0]        o_abs, c_abs, d_abs;

    // closing helpers
    logic [60:0]        m_abs;
    logic signed [33:0] t_val;
    logic [31:0]        t_abs;
    logic signed [61:0] dco_val;
    logic [61:0]        dco_abs;
    logic               tdc_neg;
    logic [wr2s_pkg::ACC_W-1:0] acc_step;
    logic [wr2s_pkg::DEN_W:0]   div_sh, div_dif;
    logic                       div_ge, div_sat;
    logic [34:0]                sq_sh, sq_trial, sq_dif;
    logic                       sq_ge;
    logic [31:0]                scale_clamp;
    logic [31:0]                q_lim;

    assign o_ext = {in_data.obs_value[19], in_data.obs_value};
    assign c_ext = {in_data.calc_value[19], in_data.calc_value};
    assign d_ext = o_ext - c_ext;
    assign o_abs = o_ext[20] ? 21'(-o_ext) : 21'(o_ext);
    assign c_abs = c_ext[20] ? 21'(-c_ext) : 21'(c_ext);
    assign d_abs = d_ext[20] ? 21'(-d_ext) : 21'(d_ext);

    // magnitude of the cross sum
    assign m_abs = sco_reg[60] ? 61'(-sco_reg) : 61'(sco_reg);

    // preset mode: t = 1.0 - preset, and the cross term sco - scc
    assign t_val   = 34'sd65536 - {{2{preset_scale_reg[31]}}, preset_scale_reg};
    assign t_abs   = t_val[33] ? 32'(-t_val) : t_val[31:0];
    assign dco_val = {sco_reg[60], sco_reg} - {2'b00, scc_reg};
    assign dco_abs = dco_val[61] ? 62'(-dco_val) : 62'(dco_val);
    assign tdc_neg = t_val[33] ^ dco_val[61];

    // one shift-add step of the multiplier
    assign acc_step = sub_reg ? (acc_reg - mula_reg) : (acc_reg + mula_reg);

    // one restoring step of the divider, and the quotient overflow test
    assign div_sh  = {rem_reg, quot_reg[63]};
    assign div_ge  = div_sh >= {1'b0, den_reg};
    assign div_dif = div_sh - {1'b0, den_reg};
    assign div_sat = {24'b0, acc_reg[159:64]} >= den_reg;

    // one digit step of the square root, two radicand bits per cycle
    assign sq_sh    = {srem_reg, quot_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_dif   = sq_sh - sq_trial;

    // scale toward zero, saturated to signed 32 bits
    always_comb
    begin
        q_lim = 32'h0;
        if (sco_reg[60])
        begin
            q_lim       = (quot_reg > 64'h8000_0000) ? 32'h8000_0000 : quot_reg[31:0];
            scale_clamp = 32'(-q_lim);
        end
        else
        begin
            scale_clamp = (quot_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot_reg[31:0];
        end
    end

    assign in_ready  = (state_reg == wr2s_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        item_count_next = item_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        soo_next        = soo_reg;
        scc_next        = scc_reg;
        sco_next        = sco_reg;
        sdd_next        = sdd_reg;
        last_next       = last_reg;
        co_neg_next     = co_neg_reg;
        w_next          = w_reg;
        cand_o_next     = cand_o_reg;
        cand_c_next     = cand_c_reg;
        cand_d_next     = cand_d_reg;
        mult_o_next     = mult_o_reg;
        mult_c_next     = mult_c_reg;
        mult_d_next     = mult_d_reg;
        poo_next        = poo_reg;
        pcc_next        = pcc_reg;
        pco_next        = pco_reg;
        pdd_next        = pdd_reg;
        acc_next        = acc_reg;
        mula_next       = mula_reg;
        mulb_next       = mulb_reg;
        sub_next        = sub_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        root_next       = root_reg;
        srem_next       = srem_reg;
        wr2_next        = wr2_reg;
        scl_next        = scl_reg;
        err_next        = err_reg;
        out_data_next   = out_data_reg;

        case (state_reg)
            wr2s_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_data.last;
                    cnt_next  = '0;
                    if (item_count_reg < wr2s_pkg::ITEM_LIMIT)
                    begin
                        // start the bit-serial squares of this transaction
                        item_count_next = item_count_reg + 13'd1;
                        co_neg_next     = in_data.obs_value[19] ^ in_data.calc_value[19];
                        w_next          = in_data.weight;
                        cand_o_next     = {21'b0, o_abs};
                        cand_c_next     = {21'b0, c_abs};
                        cand_d_next     = {21'b0, d_abs};
                        mult_o_next     = o_abs;
                        mult_c_next     = c_abs;
                        mult_d_next     = d_abs;
                        poo_next        = '0;
                        pcc_next        = '0;
                        pco_next        = '0;
                        pdd_next        = '0;
                        state_next      = wr2s_pkg::S_PROD;
                    end
                    else
                    begin
                        // set is full: drop the transaction from the sums
                        item_count_next = wr2s_pkg::ITEM_OVER;
                        state_next = in_data.last ? wr2s_pkg::S_CHECK : wr2s_pkg::S_IDLE;
                    end
                end
            end

            wr2s_pkg::S_PROD:
            begin
                if (mult_o_reg[0])
                begin
                    poo_next = poo_reg + {10'b0, cand_o_reg};
                    pco_next = pco_reg + {10'b0, cand_c_reg};
                end
                if (mult_c_reg[0])
                begin
                    pcc_next = pcc_reg + {10'b0, cand_c_reg};
                end
                if (mult_d_reg[0])
                begin
                    pdd_next = pdd_reg + {10'b0, cand_d_reg};
                end
                cand_o_next = {cand_o_reg[40:0], 1'b0};
                cand_c_next = {cand_c_reg[40:0], 1'b0};
                cand_d_next = {cand_d_reg[40:0], 1'b0};
                mult_o_next = {1'b0, mult_o_reg[20:1]};
                mult_c_next = {1'b0, mult_c_reg[20:1]};
                mult_d_next = {1'b0, mult_d_reg[20:1]};
                if (cnt_reg == wr2s_pkg::PROD_END)
                begin
                    cnt_next   = '0;
                    state_next = wr2s_pkg::S_WACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            wr2s_pkg::S_WACC:
            begin
                if (w_reg[0])
                begin
                    soo_next = soo_reg + {8'b0, poo_reg};
                    scc_next = scc_reg + {8'b0, pcc_reg};
                    sdd_next = sdd_reg + {10'b0, pdd_reg};
                    sco_next = co_neg_reg ? (sco_reg - $signed({9'b0, pco_reg}))
                                          : (sco_reg + $signed({9'b0, pco_reg}));
                end
                poo_next = {poo_reg[50:0], 1'b0};
                pcc_next = {pcc_reg[50:0], 1'b0};
                pco_next = {pco_reg[50:0], 1'b0};
                pdd_next = {pdd_reg[50:0], 1'b0};
                w_next   = {1'b0, w_reg[9:1]};
                if (cnt_reg == wr2s_pkg::WACC_END)
                begin
                    cnt_next   = '0;
                    state_next = last_reg ? wr2s_pkg::S_CHECK : wr2s_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            wr2s_pkg::S_CHECK:
            begin
                wr2_next = '0;
                scl_next = '0;
                cnt_next = '0;
                acc_next = '0;
                sub_next = 1'b0;
                err_next = wr2s_pkg::ERR_OK;
                if (item_count_reg > wr2s_pkg::ITEM_LIMIT)
                begin
                    err_next   = wr2s_pkg::ERR_OVERFLOW;
                    state_next = wr2s_pkg::S_OUT;
                end
                else if (soo_reg == '0)
                begin
                    err_next   = wr2s_pkg::ERR_OBS_ZERO;
                    state_next = wr2s_pkg::S_OUT;
                end
                else if (!scale_mode_reg && scc_reg == '0)
                begin
                    err_next   = wr2s_pkg::ERR_CALC_ZERO;
                    state_next = wr2s_pkg::S_OUT;
                end
                else if (!scale_mode_reg)
                begin
                    // denominator soo * scc
                    mula_next  = {100'b0, scc_reg};
                    mulb_next  = {4'b0, soo_reg};
                    step_next  = wr2s_pkg::STEP_DEN;
                    state_next = wr2s_pkg::S_MUL;
                end
                else
                begin
                    // t squared
                    mula_next  = {128'b0, t_abs};
                    mulb_next  = {32'b0, t_abs};
                    step_next  = wr2s_pkg::STEP_TT;
                    state_next = wr2s_pkg::S_MUL;
                end
            end

            wr2s_pkg::S_MUL:
            begin
                if (mulb_reg[0])
                begin
                    acc_next = acc_step;
                end
                mula_next = {mula_reg[158:0], 1'b0};
                mulb_next = {1'b0, mulb_reg[63:1]};
                if (cnt_reg == wr2s_pkg::MUL_END)
                begin
                    cnt_next   = '0;
                    state_next = wr2s_pkg::S_STEP;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            wr2s_pkg::S_STEP:
            begin
                case (step_reg)
                    wr2s_pkg::STEP_DEN:
                    begin
                        // keep soo*scc, subtract the cross sum squared
                        den_next   = acc_reg[119:0];
                        mula_next  = {99'b0, m_abs};
                        mulb_next  = {3'b0, m_abs};
                        sub_next   = 1'b1;
                        step_next  = wr2s_pkg::STEP_NUM;
                        state_next = wr2s_pkg::S_MUL;
                    end
                    wr2s_pkg::STEP_NUM:
                    begin
                        acc_next   = {acc_reg[127:0], 32'b0};
                        state_next = wr2s_pkg::S_DIVLD;
                    end
                    wr2s_pkg::STEP_TT:
                    begin
                        // diff sum << 32, then add t^2 * scc
                        den_next   = {56'b0, acc_reg[63:0]};
                        acc_next   = {66'b0, sdd_reg, 32'b0};
                        mula_next  = {100'b0, scc_reg};
                        mulb_next  = acc_reg[63:0];
                        sub_next   = 1'b0;
                        step_next  = wr2s_pkg::STEP_TSC;
                        state_next = wr2s_pkg::S_MUL;
                    end
                    wr2s_pkg::STEP_TSC:
                    begin
                        // cross term 2 * t * (sco - scc) << 16
                        mula_next  = {81'b0, dco_abs, 17'b0};
                        mulb_next  = {32'b0, t_abs};
                        sub_next   = tdc_neg;
                        step_next  = wr2s_pkg::STEP_TDC;
                        state_next = wr2s_pkg::S_MUL;
                    end
                    wr2s_pkg::STEP_TDC:
                    begin
                        den_next   = {60'b0, soo_reg};
                        state_next = wr2s_pkg::S_DIVLD;
                    end
                    default:
                    begin
                        state_next = wr2s_pkg::S_IDLE;
                    end
                endcase
            end

            wr2s_pkg::S_DIVLD:
            begin
                cnt_next = '0;
                if (div_sat)
                begin
                    quot_next  = '1;
                    state_next = wr2s_pkg::S_AFTDIV;
                end
                else
                begin
                    rem_next   = {24'b0, acc_reg[159:64]};
                    quot_next  = acc_reg[63:0];
                    state_next = wr2s_pkg::S_DIV;
                end
            end

            wr2s_pkg::S_DIV:
            begin
                rem_next  = div_ge ? div_dif[119:0] : div_sh[119:0];
                quot_next = {quot_reg[62:0], div_ge};
                if (cnt_reg == wr2s_pkg::DIV_END)
                begin
                    cnt_next   = '0;
                    state_next = wr2s_pkg::S_AFTDIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            wr2s_pkg::S_AFTDIV:
            begin
                cnt_next = '0;
                if (step_reg == wr2s_pkg::STEP_SCL)
                begin
                    scl_next   = scale_clamp;
                    state_next = wr2s_pkg::S_OUT;
                end
                else
                begin
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = wr2s_pkg::S_SQRT;
                end
            end

            wr2s_pkg::S_SQRT:
            begin
                srem_next = sq_ge ? sq_dif[32:0] : sq_sh[32:0];
                root_next = {root_reg[30:0], sq_ge};
                quot_next = {quot_reg[61:0], 2'b00};
                if (cnt_reg == wr2s_pkg::SQRT_END)
                begin
                    cnt_next = '0;
                    wr2_next = {root_reg[30:0], sq_ge};
                    if (step_reg == wr2s_pkg::STEP_NUM)
                    begin
                        // least-squares scale: |sco| << 16 / scc
                        acc_next   = {83'b0, m_abs, 16'b0};
                        den_next   = {60'b0, scc_reg};
                        step_next  = wr2s_pkg::STEP_SCL;
                        state_next = wr2s_pkg::S_DIVLD;
                    end
                    else
                    begin
                        scl_next   = preset_scale_reg;
                        state_next = wr2s_pkg::S_OUT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            wr2s_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.wr2_value  = wr2_reg;
                    out_data_next.scale_used = scl_reg;
                    out_data_next.error_code = err_reg;
                    soo_next        = '0;
                    scc_next        = '0;
                    sco_next        = '0;
                    sdd_next        = '0;
                    item_count_next = '0;
                    state_next      = wr2s_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wr2s_pkg::S_IDLE;
            end
        endcase
    end

    // control and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wr2s_pkg::S_IDLE;
            step_reg       <= wr2s_pkg::STEP_DEN;
            cnt_reg        <= '0;
            item_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            soo_reg        <= '0;
            scc_reg        <= '0;
            sco_reg        <= '0;
            sdd_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            item_count_reg <= item_count_next;
            out_valid_reg  <= out_valid_next;
            soo_reg        <= soo_next;
            scc_reg        <= scc_next;
            sco_reg        <= sco_next;
            sdd_reg        <= sdd_next;
        end
    end

    // configuration registers: mode from bit 0, preset scale from the full write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mode_reg   <= 1'b0;
            preset_scale_reg <= wr2s_pkg::PRESET_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == wr2s_pkg::REG_SCALE_MODE)
            begin
                scale_mode_reg <= wr_data[0];
            end
            else if (wr_index == wr2s_pkg::REG_PRESET_SCALE)
            begin
                preset_scale_reg <= wr_data;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        co_neg_reg   <= co_neg_next;
        w_reg        <= w_next;
        cand_o_reg   <= cand_o_next;
        cand_c_reg   <= cand_c_next;
        cand_d_reg   <= cand_d_next;
        mult_o_reg   <= mult_o_next;
        mult_c_reg   <= mult_c_next;
        mult_d_reg   <= mult_d_next;
        poo_reg      <= poo_next;
        pcc_reg      <= pcc_next;
        pco_reg      <= pco_next;
        pdd_reg      <= pdd_next;
        acc_reg      <= acc_next;
        mula_reg     <= mula_next;
        mulb_reg     <= mulb_next;
        sub_reg      <= sub_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        wr2_reg      <= wr2_next;
        scl_reg      <= scl_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    // item count never runs past the overflow mark
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= wr2s_pkg::ITEM_OVER)
        else $error("item count past overflow mark");

    // an error result carries zero factor and zero scale
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.error_code != wr2s_pkg::ERR_OK)
        |-> (out_data_reg.wr2_value == '0 && out_data_reg.scale_used == '0))
        else $error("error result with nonzero payload");

    // restoring divider keeps its partial remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wr2s_pkg::S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // sums are cleared once a result is handed to the output register
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wr2s_pkg::S_OUT && (!out_valid_reg || out_ready))
        |=> (item_count_reg == '0 && soo_reg == '0 && scc_reg == '0 && out_valid_reg))
        else $error("sums not cleared after result");

endmodule
